// File: hdl/rsfc_pkg.sv
// ----------------------------------------------------------------------------
// rsfc_pkg - shared types, constants and microcode for the scan calibrator
// Field widths, level thresholds, the micro-op and condition encodings, the
// control store contents and the Q16.16 saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfc_pkg;

  // Field widths
  localparam int RAW_W       = 16;
  localparam int SCALE_W     = 24;
  localparam int VOLT_W      = 24;
  localparam int PIX_W       = 32;
  localparam int LEN_W       = 10;
  localparam int COEF_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_PAD_W   = OUT_DATA_W - PIX_W - LEN_W;
  localparam int COEF_IDX_W  = 2;
  localparam int SUM_W       = 42;

  // Levels in Q8.16 volts
  localparam logic signed [VOLT_W-1:0] DIP_LEVEL   = -24'sd622592;
  localparam logic signed [VOLT_W-1:0] RISE_LEVEL  = -24'sd327680;
  localparam logic signed [VOLT_W-1:0] CLOSE_LEVEL = 24'sd622592;

  localparam int LEAD_SKIP   = 3;
  localparam int DELAY_DEPTH = 3;
  localparam int LEN_DROP    = 2;

  typedef logic [3:0][COEF_W-1:0] coef_set_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_OFFSET,
    REG_VOLTS_SCALE,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_REF_VOLTAGE,
    REG_REF_BRIGHTNESS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_DIP,
    PH_RISE,
    PH_LEAD,
    PH_SCAN
  } phase_t;

  // Micro-ops driving the datapath
  typedef enum logic [3:0] {
    UOP_WAIT,
    UOP_VMUL,
    UOP_VSAT,
    UOP_FRAME,
    UOP_NOP,
    UOP_HLOAD,
    UOP_HMUL,
    UOP_HADD,
    UOP_BRIGHT,
    UOP_EMIT,
    UOP_SEEK
  } uop_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NO_EMIT,
    C_H_DONE,
    C_H_MORE,
    C_OUT_BUSY,
    C_SEEK_MORE
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Status into the sequencer's condition mux
  typedef struct packed {
    logic in_valid;
    logic emit;
    logic h_done;
    logic out_busy;
    logic seek_more;
  } cond_flags_t;

  // Framer result for the current request
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             ovf;
    logic [LEN_W-1:0] len;
    logic             seek_more;
  } frame_stat_t;

  // Step labels used as jump targets
  localparam step_t ST_WAIT   = 4'd0;
  localparam step_t ST_HMUL   = 4'd6;
  localparam step_t ST_BRIGHT = 4'd8;
  localparam step_t ST_EMIT   = 4'd9;
  localparam step_t ST_SEEK   = 4'd10;

  // Control store
  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    unique case (s)
      4'd0:    w = '{UOP_WAIT,   C_NO_INPUT,  ST_WAIT};
      4'd1:    w = '{UOP_VMUL,   C_NEVER,     ST_WAIT};
      4'd2:    w = '{UOP_VSAT,   C_NEVER,     ST_WAIT};
      4'd3:    w = '{UOP_FRAME,  C_NEVER,     ST_WAIT};
      4'd4:    w = '{UOP_NOP,    C_NO_EMIT,   ST_SEEK};
      4'd5:    w = '{UOP_HLOAD,  C_H_DONE,    ST_BRIGHT};
      4'd6:    w = '{UOP_HMUL,   C_NEVER,     ST_WAIT};
      4'd7:    w = '{UOP_HADD,   C_H_MORE,    ST_HMUL};
      4'd8:    w = '{UOP_BRIGHT, C_NEVER,     ST_WAIT};
      4'd9:    w = '{UOP_EMIT,   C_OUT_BUSY,  ST_EMIT};
      4'd10:   w = '{UOP_SEEK,   C_SEEK_MORE, ST_SEEK};
      default: w = '{UOP_NOP,    C_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

  // Saturate a wide two's complement sum to signed 32 bits
  function automatic logic [PIX_W-1:0] sat_pix(input logic [SUM_W-1:0] s);
    logic [PIX_W-1:0] r;
    if (s[SUM_W-1:PIX_W-1] == {(SUM_W-PIX_W+1){s[SUM_W-1]}}) begin
      r = s[PIX_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(PIX_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(PIX_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/radiometer_scan_framer_calibrator_core.sv
// ----------------------------------------------------------------------------
// radiometer_scan_framer_calibrator_core - scan framer and pixel calibrator
// Converts ADC samples to volts, frames scans and calibrates the scan samples
// leaving the delay line through a Horner polynomial, under a microcoded sequencer.
// ----------------------------------------------------------------------------
// Flow: a new request is taken only once the previous one, with its pixel and any
// replay of held samples, is through; pace set by the single shared multiplier and
// the sequencer walking one control word a cycle; a stalled output holds it.
// Reset (rst, synchronous): search for a dip, delay line empty, registers at
// their defaults; no clearing pass.
`default_nettype none

module radiometer_scan_framer_calibrator_core #(
  parameter int MAX_SCAN_SAMPLES = 512,
  parameter int MIN_SCAN_SPAN    = 340,
  parameter int COEF_COUNT       = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [rsfc_pkg::IN_DATA_W-1:0]     s_tdata,   // [15:0] raw_sample
  // output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [rsfc_pkg::OUT_DATA_W-1:0]         m_tdata,   // [31:0] pixel, [41:32] scan_length
  output logic                                    m_tlast,   // last_of_scan
  output logic                                    m_tuser,   // [0] overflow
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [rsfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [rsfc_pkg::RAW_W-1:0]    adc_offset;
  logic [rsfc_pkg::SCALE_W-1:0]  volts_scale;
  rsfc_pkg::coef_set_t           coef;
  logic [rsfc_pkg::VOLT_W-1:0]   ref_voltage;
  logic [rsfc_pkg::PIX_W-1:0]    ref_brightness;

  rsfc_pkg::uop_t                uop;
  rsfc_pkg::cond_flags_t         flags;
  rsfc_pkg::frame_stat_t         stat;
  logic signed [rsfc_pkg::VOLT_W-1:0] volts;
  logic [rsfc_pkg::VOLT_W-1:0]   delay_head;
  logic [rsfc_pkg::PIX_W-1:0]    pixel;
  logic                          h_done;
  logic                          out_busy;
  logic                          out_load;

  logic [rsfc_pkg::PIX_W-1:0]    out_pixel;
  logic [rsfc_pkg::LEN_W-1:0]    out_len;
  logic                          out_last;
  logic                          out_ovf;

  assign s_tready = (uop == rsfc_pkg::UOP_WAIT);
  assign out_busy = m_tvalid && !m_tready;
  assign out_load = (uop == rsfc_pkg::UOP_EMIT) && !out_busy;

  assign flags.in_valid  = s_tvalid;
  assign flags.emit      = stat.emit;
  assign flags.h_done    = h_done;
  assign flags.out_busy  = out_busy;
  assign flags.seek_more = stat.seek_more;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_offset     <= '0;
      volts_scale    <= 24'd5120;
      coef[0]        <= 32'd0;
      coef[1]        <= 32'd65536;
      coef[2]        <= 32'd0;
      coef[3]        <= 32'd0;
      ref_voltage    <= '0;
      ref_brightness <= '0;
    end else if (cfg_wr_en) begin
      unique case (rsfc_pkg::cfg_reg_t'(cfg_index))
        rsfc_pkg::REG_ADC_OFFSET:     adc_offset     <= cfg_data[rsfc_pkg::RAW_W-1:0];
        rsfc_pkg::REG_VOLTS_SCALE:    volts_scale    <= cfg_data[rsfc_pkg::SCALE_W-1:0];
        rsfc_pkg::REG_COEF_0:         coef[0]        <= cfg_data;
        rsfc_pkg::REG_COEF_1:         coef[1]        <= cfg_data;
        rsfc_pkg::REG_COEF_2:         coef[2]        <= cfg_data;
        rsfc_pkg::REG_COEF_3:         coef[3]        <= cfg_data;
        rsfc_pkg::REG_REF_VOLTAGE:    ref_voltage    <= cfg_data[rsfc_pkg::VOLT_W-1:0];
        rsfc_pkg::REG_REF_BRIGHTNESS: ref_brightness <= cfg_data;
      endcase
    end
  end

  rsfc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uop   (uop)
  );

  rsfc_calc #(
    .COEF_COUNT (COEF_COUNT)
  ) u_calc (
    .clk            (clk),
    .rst            (rst),
    .uop            (uop),
    .in_take        (s_tvalid && s_tready),
    .raw_in         (s_tdata[rsfc_pkg::RAW_W-1:0]),
    .adc_offset     (adc_offset),
    .volts_scale    (volts_scale),
    .coef           (coef),
    .ref_voltage    (ref_voltage),
    .ref_brightness (ref_brightness),
    .delay_head     (delay_head),
    .volts          (volts),
    .pixel          (pixel),
    .h_done         (h_done)
  );

  rsfc_framer #(
    .MAX_SCAN_SAMPLES (MAX_SCAN_SAMPLES),
    .MIN_SCAN_SPAN    (MIN_SCAN_SPAN)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .uop        (uop),
    .volts      (volts),
    .delay_head (delay_head),
    .stat       (stat)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel <= pixel;
      out_last  <= stat.last;
      out_ovf   <= stat.ovf;
      out_len   <= stat.len;
    end
  end

  assign m_tdata = {{rsfc_pkg::OUT_PAD_W{1'b0}}, out_len, out_pixel};
  assign m_tlast = out_last;
  assign m_tuser = out_ovf;

endmodule

`default_nettype wire

// File: hdl/rsfc_seq.sv
// ----------------------------------------------------------------------------
// rsfc_seq - microcode sequencer
// Step counter over the control store; each step either falls through or
// jumps to its target when the selected condition holds.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rsfc_pkg::cond_flags_t flags,
  output rsfc_pkg::uop_t            uop
);

  rsfc_pkg::step_t      step;
  rsfc_pkg::step_t      step_next;
  rsfc_pkg::ctrl_word_t cw;
  logic                 take;

  assign cw  = rsfc_pkg::ucode(step);
  assign uop = cw.uop;

  // Condition select
  always_comb begin
    unique case (cw.cond)
      rsfc_pkg::C_NEVER:     take = 1'b0;
      rsfc_pkg::C_ALWAYS:    take = 1'b1;
      rsfc_pkg::C_NO_INPUT:  take = !flags.in_valid;
      rsfc_pkg::C_NO_EMIT:   take = !flags.emit;
      rsfc_pkg::C_H_DONE:    take = flags.h_done;
      rsfc_pkg::C_H_MORE:    take = !flags.h_done;
      rsfc_pkg::C_OUT_BUSY:  take = flags.out_busy;
      rsfc_pkg::C_SEEK_MORE: take = flags.seek_more;
    endcase
  end

  assign step_next = take ? cw.target : step + 4'd1;

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rsfc_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rsfc_calc.sv
// ----------------------------------------------------------------------------
// rsfc_calc - arithmetic datapath
// One shared 25x32 signed multiplier serves both the volts conversion and
// the Horner steps; results saturate into Q8.16 volts or Q16.16 pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_calc #(
  parameter int COEF_COUNT = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire rsfc_pkg::uop_t                        uop,
  input  wire logic                                  in_take,
  input  wire logic        [rsfc_pkg::RAW_W-1:0]     raw_in,
  input  wire logic        [rsfc_pkg::RAW_W-1:0]     adc_offset,
  input  wire logic        [rsfc_pkg::SCALE_W-1:0]   volts_scale,
  input  wire rsfc_pkg::coef_set_t                   coef,
  input  wire logic        [rsfc_pkg::VOLT_W-1:0]    ref_voltage,
  input  wire logic        [rsfc_pkg::PIX_W-1:0]     ref_brightness,
  input  wire logic        [rsfc_pkg::VOLT_W-1:0]    delay_head,
  output logic signed      [rsfc_pkg::VOLT_W-1:0]    volts,
  output logic             [rsfc_pkg::PIX_W-1:0]     pixel,
  output logic                                       h_done
);

  localparam int CW = rsfc_pkg::COEF_IDX_W;
  localparam int SW = rsfc_pkg::SUM_W;

  logic        [rsfc_pkg::RAW_W-1:0]   raw;
  logic signed [rsfc_pkg::RAW_W:0]     diff;
  logic signed [24:0]                  mul_a;
  logic signed [31:0]                  mul_b;
  logic signed [56:0]                  mprod;
  logic        [24:0]                  x;
  logic        [rsfc_pkg::PIX_W-1:0]   acc;
  logic        [CW-1:0]                k;
  logic        [rsfc_pkg::COEF_W-1:0]  coef_sel;
  logic        [SW-1:0]                sum_h;
  logic        [SW-1:0]                sum_b;

  // Multiplier operands
  assign diff = $signed({raw[rsfc_pkg::RAW_W-1], raw})
              - $signed({adc_offset[rsfc_pkg::RAW_W-1], adc_offset});

  always_comb begin
    if (uop == rsfc_pkg::UOP_VMUL) begin
      mul_a = {{8{diff[rsfc_pkg::RAW_W]}}, diff};
      mul_b = $signed({8'd0, volts_scale});
    end else begin
      mul_a = $signed(x);
      mul_b = $signed(acc);
    end
  end

  // Horner add and brightness add
  assign coef_sel = coef[k - CW'(1)];
  assign sum_h    = {mprod[56], mprod[56:16]} + {{(SW-32){coef_sel[31]}}, coef_sel};
  assign sum_b    = {{(SW-32){acc[31]}}, acc}
                  + {{(SW-32){ref_brightness[31]}}, ref_brightness};

  assign h_done = (uop == rsfc_pkg::UOP_HLOAD) ? (COEF_COUNT == 1) : (k == CW'(1));
  assign pixel  = acc;

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      raw <= raw_in;
    end
    if (uop == rsfc_pkg::UOP_VMUL || uop == rsfc_pkg::UOP_HMUL) begin
      mprod <= mul_a * mul_b;
    end
    // floor shift by 8, clamp to Q8.16
    if (uop == rsfc_pkg::UOP_VSAT) begin
      if (mprod[56:31] == {26{mprod[56]}}) begin
        volts <= mprod[31:8];
      end else if (mprod[56]) begin
        volts <= 24'sh800000;
      end else begin
        volts <= 24'sh7FFFFF;
      end
    end
    if (uop == rsfc_pkg::UOP_FRAME) begin
      x <= {delay_head[23], delay_head} - {ref_voltage[23], ref_voltage};
    end
    unique case (uop)
      rsfc_pkg::UOP_HLOAD:  acc <= coef[CW'(COEF_COUNT-1)];
      rsfc_pkg::UOP_HADD:   acc <= rsfc_pkg::sat_pix(sum_h);
      rsfc_pkg::UOP_BRIGHT: acc <= rsfc_pkg::sat_pix(sum_b);
      default: ;
    endcase
  end

  // Horner step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (uop == rsfc_pkg::UOP_HLOAD) begin
      k <= CW'(COEF_COUNT-1);
    end else if (uop == rsfc_pkg::UOP_HADD) begin
      k <= k - CW'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/rsfc_framer.sv
// ----------------------------------------------------------------------------
// rsfc_framer - scan framing state
// Dip/rise search, lead skip, 3-deep delay line, pixel count and the replay
// of held samples into the search after a scan ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_framer #(
  parameter int MAX_SCAN_SAMPLES = 512,
  parameter int MIN_SCAN_SPAN    = 340
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rsfc_pkg::uop_t                     uop,
  input  wire logic signed [rsfc_pkg::VOLT_W-1:0] volts,
  output logic        [rsfc_pkg::VOLT_W-1:0]      delay_head,
  output rsfc_pkg::frame_stat_t                   stat
);

  localparam int PCNT_W   = $clog2(MAX_SCAN_SAMPLES + 1);
  localparam int SKIP_MAX = (MIN_SCAN_SPAN > rsfc_pkg::LEAD_SKIP) ?
                            MIN_SCAN_SPAN : rsfc_pkg::LEAD_SKIP;
  localparam int SKIP_W   = $clog2(SKIP_MAX + 1);
  localparam int LW       = rsfc_pkg::LEN_W;
  localparam int VW       = rsfc_pkg::VOLT_W;

  rsfc_pkg::phase_t        phase, phase_next;
  logic [SKIP_W-1:0]       skip, skip_next;
  logic [1:0]              fill, fill_next;
  logic [PCNT_W-1:0]       pcount, pcount_next;
  logic signed [VW-1:0]    delay [rsfc_pkg::DELAY_DEPTH];
  logic signed [VW-1:0]    delay_next [rsfc_pkg::DELAY_DEPTH];
  logic [3:0]              mask, mask_next;
  logic                    emit, emit_next;
  logic                    last, last_next;
  logic                    ovf, ovf_next;
  logic [LW-1:0]           len, len_next;

  logic [PCNT_W-1:0]       pcount_inc;
  logic [LW-1:0]           len_inc;
  logic                    close;
  logic signed [VW-1:0]    seek_val;
  logic [3:0]              low_bit;
  logic [SKIP_W-1:0]       skip_inc;

  assign pcount_inc = pcount + PCNT_W'(1);
  assign skip_inc   = skip + SKIP_W'(1);
  assign len_inc    = (pcount_inc >= PCNT_W'(rsfc_pkg::LEN_DROP)) ?
                      LW'(pcount_inc - PCNT_W'(rsfc_pkg::LEN_DROP)) : '0;
  assign close      = (skip >= SKIP_W'(MIN_SCAN_SPAN)) && (volts >= rsfc_pkg::CLOSE_LEVEL);

  // Outputs: replay head select, status
  always_comb begin
    priority if (mask[0]) begin
      low_bit  = 4'b0001;
      seek_val = delay[0];
    end else if (mask[1]) begin
      low_bit  = 4'b0010;
      seek_val = delay[1];
    end else if (mask[2]) begin
      low_bit  = 4'b0100;
      seek_val = delay[2];
    end else begin
      low_bit  = mask & 4'b1000;
      seek_val = volts;
    end
    delay_head     = delay[0];
    stat.emit      = emit;
    stat.last      = last;
    stat.ovf       = ovf;
    stat.len       = len;
    stat.seek_more = |(mask & ~low_bit);
  end

  // Next state
  always_comb begin
    phase_next  = phase;
    skip_next   = skip;
    fill_next   = fill;
    pcount_next = pcount;
    delay_next  = delay;
    mask_next   = mask;
    emit_next   = emit;
    last_next   = last;
    ovf_next    = ovf;
    len_next    = len;
    unique case (uop)
      rsfc_pkg::UOP_FRAME: begin
        emit_next = 1'b0;
        last_next = 1'b0;
        ovf_next  = 1'b0;
        len_next  = '0;
        mask_next = 4'b0000;
        if (phase != rsfc_pkg::PH_SCAN) begin
          // outside a scan the sample only feeds the search
          mask_next = 4'b1000;
        end else if (close) begin
          phase_next = rsfc_pkg::PH_DIP;
          if (fill == 2'd3) begin
            pcount_next = pcount_inc;
            emit_next   = 1'b1;
            last_next   = 1'b1;
            ovf_next    = (pcount_inc >= PCNT_W'(MAX_SCAN_SAMPLES));
            len_next    = len_inc;
            mask_next   = 4'b1110;
          end else begin
            // early close: replay what was held, then the sample
            unique case (fill)
              2'd0:    mask_next = 4'b1000;
              2'd1:    mask_next = 4'b1001;
              default: mask_next = 4'b1011;
            endcase
          end
        end else begin
          if (skip < SKIP_W'(MIN_SCAN_SPAN)) begin
            skip_next = skip_inc;
          end
          if (fill != 2'd3) begin
            delay_next[fill] = volts;
            fill_next        = fill + 2'd1;
          end else begin
            delay_next[0] = delay[1];
            delay_next[1] = delay[2];
            delay_next[2] = volts;
            pcount_next   = pcount_inc;
            emit_next     = 1'b1;
            if (pcount_inc >= PCNT_W'(MAX_SCAN_SAMPLES)) begin
              last_next  = 1'b1;
              ovf_next   = 1'b1;
              len_next   = len_inc;
              phase_next = rsfc_pkg::PH_DIP;
              mask_next  = 4'b0111;
            end
          end
        end
      end
      rsfc_pkg::UOP_SEEK: begin
        mask_next = mask & ~low_bit;
        if (mask != 4'b0000) begin
          unique case (phase)
            rsfc_pkg::PH_DIP: begin
              if (seek_val < rsfc_pkg::DIP_LEVEL) begin
                phase_next = rsfc_pkg::PH_RISE;
              end
            end
            rsfc_pkg::PH_RISE: begin
              if (seek_val >= rsfc_pkg::RISE_LEVEL) begin
                phase_next = rsfc_pkg::PH_LEAD;
                skip_next  = '0;
              end
            end
            rsfc_pkg::PH_LEAD: begin
              if (skip_inc >= SKIP_W'(rsfc_pkg::LEAD_SKIP)) begin
                phase_next  = rsfc_pkg::PH_SCAN;
                skip_next   = '0;
                fill_next   = '0;
                pcount_next = '0;
              end else begin
                skip_next = skip_inc;
              end
            end
            rsfc_pkg::PH_SCAN: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= rsfc_pkg::PH_DIP;
      skip   <= '0;
      fill   <= '0;
      pcount <= '0;
      mask   <= '0;
      emit   <= 1'b0;
      last   <= 1'b0;
      ovf    <= 1'b0;
      len    <= '0;
      delay  <= '{default: '0};
    end else begin
      phase  <= phase_next;
      skip   <= skip_next;
      fill   <= fill_next;
      pcount <= pcount_next;
      mask   <= mask_next;
      emit   <= emit_next;
      last   <= last_next;
      ovf    <= ovf_next;
      len    <= len_next;
      delay  <= delay_next;
    end
  end

  // Checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == rsfc_pkg::PH_SCAN |-> pcount < PCNT_W'(MAX_SCAN_SAMPLES))
    else $error("pixel count reached limit inside an open scan");

  a_mid_pixel_keeps_scan: assert property (@(posedge clk) disable iff (rst)
    (uop == rsfc_pkg::UOP_FRAME && phase == rsfc_pkg::PH_SCAN)
      |=> (!emit || last || phase == rsfc_pkg::PH_SCAN))
    else $error("scan left without a final pixel");

  a_flags_need_emit: assert property (@(posedge clk) disable iff (rst)
    (!last || emit) && (!ovf || last))
    else $error("last or overflow flag without a pixel");

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the radiometer scan framer and calibrator
// A queue of ADC samples feeds a stream driver; a monitor predicts the
// calibrated pixels of each accepted request with an in-bench model of the
// framer and Horner datapath, then checks every output beat against them.
// Phases switch register settings and the idle/stall pattern on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int SCAN_LIMIT    = 512;
  localparam int CLOSE_HOLDOFF = 340;
  localparam int POLY_TERMS    = 4;
  localparam int LEAD_LEN      = 3;
  localparam int DLY_LEN       = 3;

  // Q8.16 thresholds
  localparam logic signed [23:0] V_DIP   = -24'sd622592;
  localparam logic signed [23:0] V_RISE  = -24'sd327680;
  localparam logic signed [23:0] V_CLOSE = 24'sd622592;

  // Kinds of sample the stimulus aims for
  typedef enum int {
    LV_ANY,
    LV_LOW,
    LV_BELOW_RISE,
    LV_RISE,
    LV_MID,
    LV_NOHIGH,
    LV_HIGH
  } level_t;

  typedef struct {
    logic signed [31:0] pixel;
    logic               last;
    logic               ovf;
    logic [9:0]         len;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Register shadow
  longint adc_off, volts_gain, ref_v, ref_b;
  longint poly_coef [4];

  // Framer shadow
  rsfc_pkg::phase_t   scan_phase;
  int                 lead_cnt;
  logic signed [23:0] dly [DLY_LEN];
  int                 dly_fill;
  int                 pix_cnt;

  pixel_res_t  pixel_expect_q [$];
  logic [15:0] raw_q [$];
  int          sent_cnt = 0;
  int          taken_cnt = 0;
  int          bad_cnt = 0;
  int          queued_items = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;

  radiometer_scan_framer_calibrator_core #(
    .MAX_SCAN_SAMPLES(SCAN_LIMIT),
    .MIN_SCAN_SPAN(CLOSE_HOLDOFF),
    .COEF_COUNT(POLY_TERMS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),      // [15:0] raw_sample
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),      // [31:0] pixel, [41:32] scan_length
    .m_tlast(m_tlast),      // last_of_scan
    .m_tuser(m_tuser),      // [0] overflow
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #2000000;
    $display("radiometer_scan_framer_calibrator_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic longint sat32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // ADC count to Q8.16 volts, floored and saturated to 24 bits
  function automatic logic signed [23:0] sample_volts(logic [15:0] raw);
    longint p;
    p = ((longint'($signed(raw)) - adc_off) * volts_gain) >>> 8;
    if (p > 64'sd8388607) p = 64'sd8388607;
    else if (p < -64'sd8388608) p = -64'sd8388608;
    return p[23:0];
  endfunction

  // Horner evaluation around the reference voltage, then brightness offset
  function automatic longint calibrated_pixel(logic signed [23:0] v);
    longint x;
    longint acc;
    x   = longint'(v) - ref_v;
    acc = poly_coef[POLY_TERMS-1];
    for (int k = POLY_TERMS - 2; k >= 0; k--) begin
      acc = sat32(poly_coef[k] + ((x * acc) >>> 16));
    end
    return sat32(acc + ref_b);
  endfunction

  // Dip / rise / lead-in search outside a scan
  function automatic void hunt_scan_start(logic signed [23:0] v);
    case (scan_phase)
      rsfc_pkg::PH_DIP: begin
        if (v < V_DIP) scan_phase = rsfc_pkg::PH_RISE;
      end
      rsfc_pkg::PH_RISE: begin
        if (v >= V_RISE) begin
          scan_phase = rsfc_pkg::PH_LEAD;
          lead_cnt   = 0;
        end
      end
      rsfc_pkg::PH_LEAD: begin
        lead_cnt++;
        if (lead_cnt >= LEAD_LEN) begin
          scan_phase = rsfc_pkg::PH_SCAN;
          lead_cnt   = 0;
          dly_fill   = 0;
          pix_cnt    = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_pixel(longint pix, logic last, logic ovf);
    pixel_res_t r;
    r.pixel = pix[31:0];
    r.last  = last;
    r.ovf   = last & ovf;
    r.len   = (last && pix_cnt >= 2) ? 10'(pix_cnt - 2) : '0;
    pixel_expect_q.push_back(r);
  endfunction

  // One accepted sample through the framer
  function automatic void frame_sample(logic [15:0] raw);
    logic signed [23:0] v;
    longint             pix;
    int                 first;
    v = sample_volts(raw);
    if (scan_phase != rsfc_pkg::PH_SCAN) begin
      hunt_scan_start(v);
      return;
    end
    // close: emit the oldest delayed sample if the line is full, replay the rest
    if (lead_cnt >= CLOSE_HOLDOFF && v >= V_CLOSE) begin
      first = 0;
      if (dly_fill >= DLY_LEN) begin
        pix_cnt++;
        push_pixel(calibrated_pixel(dly[0]), 1'b1, pix_cnt >= SCAN_LIMIT);
        first = 1;
      end
      scan_phase = rsfc_pkg::PH_DIP;
      for (int k = first; k < dly_fill; k++) hunt_scan_start(dly[k]);
      hunt_scan_start(v);
      return;
    end
    if (lead_cnt < CLOSE_HOLDOFF) lead_cnt++;
    if (dly_fill < DLY_LEN) begin
      dly[dly_fill] = v;
      dly_fill++;
      return;
    end
    pix    = calibrated_pixel(dly[0]);
    dly[0] = dly[1];
    dly[1] = dly[2];
    dly[2] = v;
    pix_cnt++;
    // sample limit ends the scan with the overflow flag
    if (pix_cnt >= SCAN_LIMIT) begin
      push_pixel(pix, 1'b1, 1'b1);
      scan_phase = rsfc_pkg::PH_DIP;
      for (int k = 0; k < DLY_LEN; k++) hunt_scan_start(dly[k]);
    end else begin
      push_pixel(pix, 1'b0, 1'b0);
    end
  endfunction

  function automatic void note_fail(string msg);
    bad_cnt++;
    if (bad_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: requests and output stalls change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      if (!s_tvalid || taken_cnt == sent_cnt) begin
        if (raw_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          s_tdata  <= raw_q.pop_front();
          s_tvalid <= 1'b1;
          sent_cnt++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check output beats, predict accepted requests
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_res_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pixel_expect_q.size() == 0) begin
          note_fail($sformatf("unexpected pixel %h last %b ovf %b len %0d",
                              m_tdata[31:0], m_tlast, m_tuser, m_tdata[41:32]));
        end else begin
          e = pixel_expect_q.pop_front();
          if (m_tdata[31:0] !== e.pixel || m_tlast !== e.last ||
              m_tuser !== e.ovf || m_tdata[41:32] !== e.len) begin
            note_fail($sformatf({"pixel mismatch: exp %h last %b ovf %b len %0d, ",
                                 "got %h last %b ovf %b len %0d"},
                                e.pixel, e.last, e.ovf, e.len, m_tdata[31:0],
                                m_tlast, m_tuser, m_tdata[41:32]));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        frame_sample(s_tdata);
        taken_cnt <= taken_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic set_reg(rsfc_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      rsfc_pkg::REG_ADC_OFFSET:     adc_off      = longint'($signed(val[15:0]));
      rsfc_pkg::REG_VOLTS_SCALE:    volts_gain   = longint'(val[23:0]);
      rsfc_pkg::REG_COEF_0:         poly_coef[0] = longint'($signed(val));
      rsfc_pkg::REG_COEF_1:         poly_coef[1] = longint'($signed(val));
      rsfc_pkg::REG_COEF_2:         poly_coef[2] = longint'($signed(val));
      rsfc_pkg::REG_COEF_3:         poly_coef[3] = longint'($signed(val));
      rsfc_pkg::REG_REF_VOLTAGE:    ref_v        = longint'($signed(val[23:0]));
      rsfc_pkg::REG_REF_BRIGHTNESS: ref_b        = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_config(longint off, longint scale, longint c0, longint c1,
                             longint c2, longint c3, longint rv, longint rb);
    set_reg(rsfc_pkg::REG_ADC_OFFSET, off[31:0]);
    set_reg(rsfc_pkg::REG_VOLTS_SCALE, scale[31:0]);
    set_reg(rsfc_pkg::REG_COEF_0, c0[31:0]);
    set_reg(rsfc_pkg::REG_COEF_1, c1[31:0]);
    set_reg(rsfc_pkg::REG_COEF_2, c2[31:0]);
    set_reg(rsfc_pkg::REG_COEF_3, c3[31:0]);
    set_reg(rsfc_pkg::REG_REF_VOLTAGE, rv[31:0]);
    set_reg(rsfc_pkg::REG_REF_BRIGHTNESS, rb[31:0]);
  endtask

  task automatic random_config();
    load_config(longint'(int'($urandom_range(0, 2000)) - 1000),
                longint'($urandom_range(5000, 9000)),
                longint'($signed($urandom)) >>> 8,
                longint'(int'($urandom_range(32768, 98303))),
                longint'(int'($urandom_range(0, 8191)) - 4096),
                longint'(int'($urandom_range(0, 255)) - 128),
                longint'(int'($urandom_range(0, 131072)) - 65536),
                longint'($signed($urandom)));
  endtask

  function automatic void push_raw(logic [15:0] r);
    raw_q.push_back(r);
    queued_items++;
  endfunction

  // Search for a raw count whose volts land in the wanted band
  function automatic logic [15:0] raw_for(level_t lvl);
    logic [15:0]        r;
    logic signed [23:0] v;
    bit                 ok;
    r = '0;
    for (int t = 0; t < 300; t++) begin
      case (t % 3)
        0: r = 16'($urandom);
        1: r = 16'(adc_off + longint'($urandom_range(0, 127)) - 64);
        default: r = t[2] ? 16'h7fff - 16'($urandom_range(0, 255))
                          : 16'h8000 + 16'($urandom_range(0, 255));
      endcase
      v = sample_volts(r);
      case (lvl)
        LV_LOW:        ok = v < V_DIP;
        LV_BELOW_RISE: ok = v < V_RISE;
        LV_RISE:       ok = v >= V_RISE;
        LV_MID:        ok = v >= V_RISE && v < V_CLOSE;
        LV_NOHIGH:     ok = v < V_CLOSE;
        LV_HIGH:       ok = v >= V_CLOSE;
        default:       ok = 1'b1;
      endcase
      if (ok) return r;
    end
    return r;
  endfunction

  // Dip, rise, lead-in, scan body and close; the tail may set up a replayed dip
  task automatic add_scan(int span);
    bit replay_tail;
    replay_tail = $urandom_range(0, 1);
    repeat ($urandom_range(0, 3)) push_raw(raw_for(LV_MID));
    push_raw(raw_for(LV_LOW));
    repeat ($urandom_range(0, 3)) push_raw(raw_for(LV_BELOW_RISE));
    push_raw(raw_for(LV_RISE));
    repeat (LEAD_LEN) push_raw(16'($urandom));
    for (int i = 0; i < span; i++) begin
      if (replay_tail && i == span - 2) push_raw(raw_for(LV_LOW));
      else if (replay_tail && i == span - 1) push_raw(raw_for(LV_MID));
      else if (i < CLOSE_HOLDOFF) push_raw(16'($urandom));
      else push_raw(raw_for(LV_NOHIGH));
    end
    push_raw(raw_for(LV_HIGH));
  endtask

  // Mostly well-formed scans, some noise and abandoned dips
  task automatic fill_scans(int n);
    int start;
    int pick;
    start = queued_items;
    while (queued_items - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) add_scan($urandom_range(CLOSE_HOLDOFF, CLOSE_HOLDOFF + 10));
        else if (pick < 75) add_scan($urandom_range(CLOSE_HOLDOFF + 11, SCAN_LIMIT + 1));
        else if (pick < 87) add_scan(SCAN_LIMIT + 2);  // close lands on the limit
        else add_scan($urandom_range(SCAN_LIMIT + 3, SCAN_LIMIT + 10));
      end else if (pick < 90) begin
        repeat ($urandom_range(5, 20)) push_raw(16'($urandom));
      end else begin
        push_raw(raw_for(LV_LOW));
        repeat ($urandom_range(3, 10)) push_raw(raw_for(LV_BELOW_RISE));
      end
    end
  endtask

  // Wait for every request taken and every pixel seen, then let the block settle
  task automatic drain();
    while (raw_q.size() != 0 || sent_cnt != taken_cnt || pixel_expect_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] opening [20];
    adc_off      = 0;
    volts_gain   = 5120;
    poly_coef[0] = 0;
    poly_coef[1] = 65536;
    poly_coef[2] = 0;
    poly_coef[3] = 0;
    ref_v        = 0;
    ref_b        = 0;
    scan_phase   = rsfc_pkg::PH_DIP;
    lead_cnt     = 0;
    dly_fill     = 0;
    pix_cnt      = 0;
    for (int k = 0; k < DLY_LEN; k++) dly[k] = '0;
    // dip, rise exactly on the level, lead-in, then scan body edge values
    opening = '{16'h8000, -16'sd20000, -16'sd16384, 16'h7fff, 16'h5555, 16'haaaa,
                16'h0000, 16'hffff, 16'h0001, 16'h7fff, 16'h8000, 16'h5555,
                16'haaaa, 16'sd31130, 16'sd31129, -16'sd31130, -16'sd31129,
                -16'sd16385, 16'sd100, -16'sd100};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings, no idling: directed opening and one full scan
    foreach (opening[i]) push_raw(opening[i]);
    repeat (CLOSE_HOLDOFF - 14) push_raw(16'($urandom));
    push_raw(raw_for(LV_NOHIGH));
    push_raw(16'h8000);
    push_raw(16'h0000);
    push_raw(16'sd31130);
    repeat (10) push_raw(16'($urandom));
    drain();

    // Random settings, sender idling
    random_config();
    tx_idle_pct  = 46;
    rx_stall_pct = 0;
    fill_scans(200);
    drain();

    // Saturating extremes, receiver stalling
    load_config(0, 16777215, -64'sd2147483648, 64'sd2147483647,
                -64'sd2147483648, 64'sd2147483647, -64'sd8388608, 64'sd2147483647);
    tx_idle_pct  = 0;
    rx_stall_pct = 46;
    fill_scans(200);
    drain();

    // Zero scale and most negative offset, both sides idling
    load_config(-64'sd32768, 0, 64'sd1000, -64'sd70000, 64'sd5, -64'sd3,
                64'sd8388607, -64'sd2147483648);
    tx_idle_pct  = 9;
    rx_stall_pct = 9;
    repeat (40) push_raw(16'($urandom));
    drain();

    // Random settings again, both idling
    random_config();
    fill_scans(200);
    drain();

    // Back to reset values: limit-driven close, no idling
    load_config(0, 5120, 0, 65536, 0, 0, 0, 0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    add_scan(SCAN_LIMIT + 2);
    drain();

    // Most positive offset at full scale, sender idling
    load_config(64'sd32767, 16777215, 64'sd65536, 64'sd65536, 0, 0, 0, 0);
    tx_idle_pct = 46;
    repeat (60) push_raw(raw_for(level_t'($urandom_range(0, 6))));
    drain();

    if (pixel_expect_q.size() != 0)
      note_fail($sformatf("%0d pixels never produced", pixel_expect_q.size()));
    if (bad_cnt == 0) begin
      $display("radiometer_scan_framer_calibrator_core verification clean");
    end else begin
      $display("radiometer_scan_framer_calibrator_core verification failed");
    end
    $finish;
  end

endmodule
